FILE: sv/vrst_pkg.sv
`default_nettype none

package vrst_pkg;

    // Fixed-point setup
    localparam int FRAC_BITS  = 12;   // fraction bits of the trig values
    localparam int ANGLE_BITS = 16;   // angle bits that are used

    // Port widths
    localparam int IN_W  = 16;
    localparam int ANG_W = 16;
    localparam int SCL_W = 16;
    localparam int OUT_W = 32;
    localparam int CFG_W = 32;
    localparam int IDX_W = 3;

    // Trig value, Q1.FRAC_BITS, range +/- 2^FRAC_BITS
    localparam int TW = FRAC_BITS + 2;

    // Roll, pitch and yaw stage widths: product, rounded sum, rounded result
    localparam int P1_W = IN_W + TW;
    localparam int S1_W = P1_W + 2;
    localparam int X1_W = S1_W - FRAC_BITS;
    localparam int P2_W = X1_W + TW;
    localparam int S2_W = P2_W + 2;
    localparam int X2_W = S2_W - FRAC_BITS;
    localparam int P3_W = X2_W + TW;
    localparam int S3_W = P3_W + 2;
    localparam int X3_W = S3_W - FRAC_BITS;

    // Scale and translate
    localparam int P4_W  = X3_W + SCL_W + 1;
    localparam int R4_W  = P4_W + 1;
    localparam int SH4_W = R4_W - 8;
    localparam int SUM_W = ((SH4_W > OUT_W) ? SH4_W : OUT_W) + 1;

    // CORDIC, Q.30 internal
    localparam int CW        = 33;
    localparam int ZW        = 18;
    localparam int STEPS     = 16;
    localparam int STEP_W    = 4;
    localparam int CORDIC_X0 = 652032874;

    // Register map
    typedef enum logic [IDX_W-1:0] {
        REG_YAW   = 3'd0,
        REG_PITCH = 3'd1,
        REG_ROLL  = 3'd2,
        REG_SCALE = 3'd3,
        REG_ORG_X = 3'd4,
        REG_ORG_Y = 3'd5,
        REG_ORG_Z = 3'd6
    } t_reg_idx;

    // Which angle a trig result belongs to
    typedef enum logic [1:0] {
        ANG_YAW   = 2'd0,
        ANG_PITCH = 2'd1,
        ANG_ROLL  = 2'd2
    } t_ang_sel;

    // Trig sequencer states
    typedef enum logic [1:0] {
        T_IDLE,
        T_ITER,
        T_ROUND
    } t_trig_st;

    // Trig result handed to the top level
    typedef struct packed {
        logic                  vld;
        t_ang_sel              sel;
        logic signed [TW-1:0]  cos_v;
        logic signed [TW-1:0]  sin_v;
    } t_trig_res;

    // atan(2^-i) in binary angle units (65536 per turn)
    function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            4'd0:    v = ZW'(8192);
            4'd1:    v = ZW'(4836);
            4'd2:    v = ZW'(2555);
            4'd3:    v = ZW'(1297);
            4'd4:    v = ZW'(651);
            4'd5:    v = ZW'(326);
            4'd6:    v = ZW'(163);
            4'd7:    v = ZW'(81);
            4'd8:    v = ZW'(41);
            4'd9:    v = ZW'(20);
            4'd10:   v = ZW'(10);
            4'd11:   v = ZW'(5);
            4'd12:   v = ZW'(3);
            4'd13:   v = ZW'(1);
            4'd14:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/vrst_trig.sv
`default_nettype none

// Shared iterative CORDIC: recomputes cos/sin of each angle flagged in i_req,
// one micro-rotation per cycle, then rounds, clamps and maps the quadrant.
module vrst_trig
    import vrst_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [2:0]        i_req,
    input  wire logic [ANG_W-1:0]  i_yaw,
    input  wire logic [ANG_W-1:0]  i_pitch,
    input  wire logic [ANG_W-1:0]  i_roll,
    output logic                   o_busy,
    output t_trig_res              o_res
);

    localparam logic [ANG_W-1:0]   ANG_MASK = ANG_W'({ANG_W{1'b1}} << (ANG_W - ANGLE_BITS));
    localparam int                 TSH      = 30 - FRAC_BITS;
    localparam logic signed [CW-1:0] TRND   = CW'(1 << (29 - FRAC_BITS));
    localparam logic signed [CW-1:0] TLIM   = CW'(1 << FRAC_BITS);
    localparam logic signed [CW-1:0] X0     = CW'(CORDIC_X0);

    t_trig_st               r_st, n_st;
    logic [2:0]             r_pend, n_pend;
    logic [STEP_W-1:0]      r_step, n_step;
    t_ang_sel               r_sel, n_sel;
    logic [1:0]             r_q, n_q;
    logic signed [CW-1:0]   r_x, n_x;
    logic signed [CW-1:0]   r_y, n_y;
    logic signed [ZW-1:0]   r_z, n_z;

    t_ang_sel               pick;
    logic [ANG_W-1:0]       ang_m;
    logic signed [TW-1:0]   c_fix, s_fix;

    // Round Q.30 to Q1.FRAC_BITS and clamp to +/- 1.0
    function automatic logic signed [TW-1:0] trig_fix(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] r;
        r = (v + TRND) >>> TSH;
        if (r > TLIM) begin
            r = TLIM;
        end else if (r < -TLIM) begin
            r = -TLIM;
        end
        return r[TW-1:0];
    endfunction

    // Lowest pending angle goes first
    always_comb begin
        if (r_pend[ANG_YAW]) begin
            pick  = ANG_YAW;
            ang_m = i_yaw & ANG_MASK;
        end else if (r_pend[ANG_PITCH]) begin
            pick  = ANG_PITCH;
            ang_m = i_pitch & ANG_MASK;
        end else begin
            pick  = ANG_ROLL;
            ang_m = i_roll & ANG_MASK;
        end
    end

    // Sequencer and datapath next state
    always_comb begin
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [ZW-1:0] t;
        dx     = r_y >>> r_step;
        dy     = r_x >>> r_step;
        t      = atan_lut(r_step);
        n_st   = r_st;
        n_pend = r_pend | i_req;
        n_step = r_step;
        n_sel  = r_sel;
        n_q    = r_q;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        unique case (r_st)
            T_IDLE: begin
                if (|r_pend) begin
                    n_st   = T_ITER;
                    n_sel  = pick;
                    n_q    = ang_m[ANG_W-1:ANG_W-2];
                    n_x    = X0;
                    n_y    = '0;
                    n_z    = ZW'(ang_m[ANG_W-3:0]);
                    n_step = '0;
                end
            end
            T_ITER: begin
                if (!r_z[ZW-1]) begin
                    n_x = r_x - dx;
                    n_y = r_y + dy;
                    n_z = r_z - t;
                end else begin
                    n_x = r_x + dx;
                    n_y = r_y - dy;
                    n_z = r_z + t;
                end
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_st = T_ROUND;
                end
            end
            T_ROUND: begin
                n_st   = T_IDLE;
                n_pend = (r_pend & ~(3'b001 << r_sel)) | i_req;
            end
            default: begin
                n_st = T_IDLE;
            end
        endcase
    end

    // Control state; all three angles are computed after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= T_IDLE;
            r_pend <= 3'b111;
        end else begin
            r_st   <= n_st;
            r_pend <= n_pend;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_sel  <= n_sel;
        r_q    <= n_q;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    // Quadrant mapping of the result
    always_comb begin
        c_fix       = trig_fix(r_x);
        s_fix       = trig_fix(r_y);
        o_res.vld   = (r_st == T_ROUND);
        o_res.sel   = r_sel;
        case (r_q)
            2'd0: begin
                o_res.cos_v = c_fix;
                o_res.sin_v = s_fix;
            end
            2'd1: begin
                o_res.cos_v = -s_fix;
                o_res.sin_v = c_fix;
            end
            2'd2: begin
                o_res.cos_v = -c_fix;
                o_res.sin_v = -s_fix;
            end
            default: begin
                o_res.cos_v = s_fix;
                o_res.sin_v = -c_fix;
            end
        endcase
    end

    assign o_busy = (r_st != T_IDLE) || (|r_pend);

endmodule

`default_nettype wire

FILE: sv/vertex_rotate_scale_translate.sv
// Vertex rotate (roll, pitch, yaw), scale and translate, 9-stage pipeline.
// Throughput: one vertex per cycle while busy is low; o_strobe marks a result
// once its start beat has passed stages a to h and the output register, and the receiver cannot stall.
// After reset, and after each angle write, busy is high while the shared
// CORDIC rebuilds cos/sin (reset: 3 angles).
// Reset is synchronous active low; it restores the register defaults.
`default_nettype none

module vertex_rotate_scale_translate
    import vrst_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic signed [IN_W-1:0]  i_local_x,
    input  wire logic signed [IN_W-1:0]  i_local_y,
    input  wire logic signed [IN_W-1:0]  i_local_z,
    output logic                         o_strobe,
    output logic signed [OUT_W-1:0]      o_world_x,
    output logic signed [OUT_W-1:0]      o_world_y,
    output logic signed [OUT_W-1:0]      o_world_z,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]        i_cfg_data
);

    localparam logic signed [S1_W-1:0]  RND1    = S1_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [S2_W-1:0]  RND2    = S2_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [S3_W-1:0]  RND3    = S3_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [R4_W-1:0]  RND4    = R4_W'(128);
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'({1'b0, {(OUT_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    // Configuration registers
    logic [ANG_W-1:0]          r_yaw, r_pitch, r_roll;
    logic [SCL_W-1:0]          r_scale;
    logic signed [OUT_W-1:0]   r_org_x, r_org_y, r_org_z;
    logic                      cfg_wr;
    logic [2:0]                trig_req;
    logic                      trig_busy;
    t_trig_res                 trig_res;

    // Trig values per angle
    logic signed [TW-1:0]      r_cos [0:2];
    logic signed [TW-1:0]      r_sin [0:2];

    // Stage valids: a, b, c, d, e, f, g, h, output
    logic [8:0]                r_vld;

    // Stage a: input beat
    logic signed [IN_W-1:0]    r_a_lx, r_a_ly, r_a_lz;
    // Stage b: roll products
    logic signed [P1_W-1:0]    r_b_p0, r_b_p1, r_b_p2, r_b_p3;
    logic signed [IN_W-1:0]    r_b_lz;
    // Stage c: after roll
    logic signed [X1_W-1:0]    r_c_x, r_c_y, r_c_z;
    logic signed [S1_W-1:0]    n_c_x, n_c_y;
    // Stage d: pitch products
    logic signed [P2_W-1:0]    r_d_p0, r_d_p1, r_d_p2, r_d_p3;
    logic signed [X1_W-1:0]    r_d_x;
    // Stage e: after pitch
    logic signed [X2_W-1:0]    r_e_x, r_e_y, r_e_z;
    logic signed [S2_W-1:0]    n_e_y, n_e_z;
    // Stage f: yaw products
    logic signed [P3_W-1:0]    r_f_p0, r_f_p1, r_f_p2, r_f_p3;
    logic signed [X2_W-1:0]    r_f_y;
    // Stage g: after yaw
    logic signed [X3_W-1:0]    r_g_x, r_g_y, r_g_z;
    logic signed [S3_W-1:0]    n_g_x, n_g_z;
    // Stage h: scale products
    logic signed [P4_W-1:0]    r_h_x, r_h_y, r_h_z;
    logic signed [SCL_W:0]     scale_s;

    // Scale rounding, translate and saturate
    function automatic logic [OUT_W-1:0] place(input logic signed [P4_W-1:0] p,
                                               input logic signed [OUT_W-1:0] org);
        logic signed [R4_W-1:0]  r;
        logic signed [SH4_W-1:0] sh;
        logic signed [SUM_W-1:0] s;
        r  = R4_W'(p) + RND4;
        sh = r[R4_W-1:8];
        s  = SUM_W'(sh) + SUM_W'(org);
        if (s > SAT_MAX) begin
            s = SAT_MAX;
        end else if (s < SAT_MIN) begin
            s = SAT_MIN;
        end
        return s[OUT_W-1:0];
    endfunction

    // Shared CORDIC
    vrst_trig u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (trig_req),
        .i_yaw   (r_yaw),
        .i_pitch (r_pitch),
        .i_roll  (r_roll),
        .o_busy  (trig_busy),
        .o_res   (trig_res)
    );

    assign o_cfg_ready = !trig_busy;
    assign busy        = trig_busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Angle writes ask for new trig values
    always_comb begin
        trig_req = 3'b000;
        if (cfg_wr) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_YAW:   trig_req[ANG_YAW]   = 1'b1;
                REG_PITCH: trig_req[ANG_PITCH] = 1'b1;
                REG_ROLL:  trig_req[ANG_ROLL]  = 1'b1;
                default:   trig_req = 3'b000;
            endcase
        end
    end

    // Register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw   <= '0;
            r_pitch <= '0;
            r_roll  <= '0;
            r_scale <= SCL_W'(256);
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
        end else if (cfg_wr) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_YAW:   r_yaw   <= i_cfg_data[ANG_W-1:0];
                REG_PITCH: r_pitch <= i_cfg_data[ANG_W-1:0];
                REG_ROLL:  r_roll  <= i_cfg_data[ANG_W-1:0];
                REG_SCALE: r_scale <= i_cfg_data[SCL_W-1:0];
                REG_ORG_X: r_org_x <= i_cfg_data[OUT_W-1:0];
                REG_ORG_Y: r_org_y <= i_cfg_data[OUT_W-1:0];
                REG_ORG_Z: r_org_z <= i_cfg_data[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Trig value store
    always_ff @(posedge i_clk) begin
        if (trig_res.vld) begin
            r_cos[trig_res.sel] <= trig_res.cos_v;
            r_sin[trig_res.sel] <= trig_res.sin_v;
        end
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[7:0], start && !busy};
        end
    end
    assign o_strobe = r_vld[8];

    // Rounded sums
    always_comb begin
        n_c_x   = S1_W'(r_b_p0) - S1_W'(r_b_p1) + RND1;
        n_c_y   = S1_W'(r_b_p2) + S1_W'(r_b_p3) + RND1;
        n_e_y   = S2_W'(r_d_p0) - S2_W'(r_d_p1) + RND2;
        n_e_z   = S2_W'(r_d_p2) + S2_W'(r_d_p3) + RND2;
        n_g_x   = S3_W'(r_f_p0) + S3_W'(r_f_p1) + RND3;
        n_g_z   = S3_W'(r_f_p2) - S3_W'(r_f_p3) + RND3;
        scale_s = $signed({1'b0, r_scale});
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        // a: input beat
        if (start && !busy) begin
            r_a_lx <= i_local_x;
            r_a_ly <= i_local_y;
            r_a_lz <= i_local_z;
        end
        // b: roll about z
        r_b_p0 <= P1_W'(r_a_lx) * P1_W'(r_cos[ANG_ROLL]);
        r_b_p1 <= P1_W'(r_a_ly) * P1_W'(r_sin[ANG_ROLL]);
        r_b_p2 <= P1_W'(r_a_lx) * P1_W'(r_sin[ANG_ROLL]);
        r_b_p3 <= P1_W'(r_a_ly) * P1_W'(r_cos[ANG_ROLL]);
        r_b_lz <= r_a_lz;
        // c
        r_c_x <= n_c_x[S1_W-1:FRAC_BITS];
        r_c_y <= n_c_y[S1_W-1:FRAC_BITS];
        r_c_z <= X1_W'(r_b_lz);
        // d: pitch about x
        r_d_p0 <= P2_W'(r_c_y) * P2_W'(r_cos[ANG_PITCH]);
        r_d_p1 <= P2_W'(r_c_z) * P2_W'(r_sin[ANG_PITCH]);
        r_d_p2 <= P2_W'(r_c_y) * P2_W'(r_sin[ANG_PITCH]);
        r_d_p3 <= P2_W'(r_c_z) * P2_W'(r_cos[ANG_PITCH]);
        r_d_x  <= r_c_x;
        // e
        r_e_x <= X2_W'(r_d_x);
        r_e_y <= n_e_y[S2_W-1:FRAC_BITS];
        r_e_z <= n_e_z[S2_W-1:FRAC_BITS];
        // f: yaw about y
        r_f_p0 <= P3_W'(r_e_x) * P3_W'(r_cos[ANG_YAW]);
        r_f_p1 <= P3_W'(r_e_z) * P3_W'(r_sin[ANG_YAW]);
        r_f_p2 <= P3_W'(r_e_z) * P3_W'(r_cos[ANG_YAW]);
        r_f_p3 <= P3_W'(r_e_x) * P3_W'(r_sin[ANG_YAW]);
        r_f_y  <= r_e_y;
        // g
        r_g_x <= n_g_x[S3_W-1:FRAC_BITS];
        r_g_y <= X3_W'(r_f_y);
        r_g_z <= n_g_z[S3_W-1:FRAC_BITS];
        // h: uniform scale
        r_h_x <= P4_W'(r_g_x) * P4_W'(scale_s);
        r_h_y <= P4_W'(r_g_y) * P4_W'(scale_s);
        r_h_z <= P4_W'(r_g_z) * P4_W'(scale_s);
        // output: translate and saturate
        o_world_x <= place(r_h_x, r_org_x);
        o_world_y <= place(r_h_y, r_org_y);
        o_world_z <= place(r_h_z, r_org_z);
    end

endmodule

`default_nettype wire
